// File: hdl/llag_pkg.sv
// Shared constants and types for the life-like automaton grid.
package llag_pkg;

    // Default grid edge length
    localparam int GRID_SIZE_DEF = 64;

    // Field widths
    localparam int OP_W    = 2;
    localparam int ADDR_W  = 6;
    localparam int MASK_W  = 9;
    localparam int COUNT_W = 4;
    localparam int REG_W   = 1;
    localparam int S_DATA_W = 16;
    localparam int M_DATA_W = 8;

    // Opcodes
    localparam logic [OP_W-1:0] OP_CLEAR   = 2'd0;
    localparam logic [OP_W-1:0] OP_WRITE   = 2'd1;
    localparam logic [OP_W-1:0] OP_ADVANCE = 2'd2;
    localparam logic [OP_W-1:0] OP_READ    = 2'd3;

    // Register indexes
    localparam logic [REG_W-1:0] REG_BIRTH   = 1'b0;
    localparam logic [REG_W-1:0] REG_SURVIVE = 1'b1;

    // Rule reset values: B5678 / S45678
    localparam logic [MASK_W-1:0] BIRTH_RESET   = 9'd480;
    localparam logic [MASK_W-1:0] SURVIVE_RESET = 9'd496;

    // Control to every row cell
    typedef struct packed {
        logic shift;
        logic clear;
    } t_cell_ctrl;

endpackage

// File: hdl/life_like_automaton_grid_top.sv
// Top level of the life-like automaton grid: ring of row cells plus rule unit.
//
//  Channel  | Direction | Contents
//  ---------+-----------+------------------------------------------------
//  s        | in        | opcode, row, col, value (one operation)
//  m        | out       | cell_state (one result per operation)
//  cfg      | in        | birth_mask (index 0), survive_mask (index 1)
//
//  An operation is accepted while idle. After the accepting cycle, clear takes 1 step.
//  Write, read and advance take GRID_SIZE steps: the grid rows sit in a ring of
//  GRID_SIZE row cells that rotates one row per cycle past the head (except while the
//  final step holds), where the rule unit or the write/read logic acts. o_s_tready
//  is low until the final step, so a new operation is not accepted before the current one ends.
//  The result is valid after the final step. The final step holds while an earlier
//  result still waits in the result register.
//  Synchronous active-low reset clears the grid and loads the B5678/S45678 rule.
module life_like_automaton_grid_top #(
    parameter int GRID_SIZE = llag_pkg::GRID_SIZE_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // [1:0] opcode, [7:2] row, [13:8] col, [14] value, [15] zero
    input  logic [llag_pkg::S_DATA_W-1:0] i_s_tdata,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    // [0] cell_state, [7:1] zero
    output logic [llag_pkg::M_DATA_W-1:0] o_m_tdata,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    input  logic                          i_cfg_we,
    input  logic [llag_pkg::REG_W-1:0]    i_cfg_idx,
    input  logic [llag_pkg::MASK_W-1:0]   i_cfg_data
);

    localparam int CW = $clog2(GRID_SIZE);
    localparam int AW = (CW > llag_pkg::ADDR_W) ? CW : llag_pkg::ADDR_W;
    localparam logic [CW-1:0] LAST = CW'(GRID_SIZE - 1);

    // Input field unpack
    logic [llag_pkg::OP_W-1:0]   w_in_op;
    logic [llag_pkg::ADDR_W-1:0] w_in_row;
    logic [llag_pkg::ADDR_W-1:0] w_in_col;
    logic                        w_in_val;
    logic [AW:0]                 w_in_row_ext;
    logic [AW:0]                 w_in_col_ext;
    logic                        w_in_inside;
    logic                        w_in_fire;

    assign w_in_op  = i_s_tdata[1:0];
    assign w_in_row = i_s_tdata[7:2];
    assign w_in_col = i_s_tdata[13:8];
    assign w_in_val = i_s_tdata[14];

    assign w_in_row_ext = {{(AW + 1 - llag_pkg::ADDR_W){1'b0}}, w_in_row};
    assign w_in_col_ext = {{(AW + 1 - llag_pkg::ADDR_W){1'b0}}, w_in_col};
    assign w_in_inside  = (w_in_row_ext < (AW + 1)'(GRID_SIZE))
                       && (w_in_col_ext < (AW + 1)'(GRID_SIZE));
    assign w_in_fire    = i_s_tvalid && o_s_tready;

    // Operation registers
    logic                        r_busy;
    logic [llag_pkg::OP_W-1:0]   r_op;
    logic [llag_pkg::ADDR_W-1:0] r_row;
    logic [llag_pkg::ADDR_W-1:0] r_col;
    logic                        r_val;
    logic                        r_inside;
    logic                        r_res;
    logic [CW-1:0]               r_cnt;
    logic [GRID_SIZE-1:0]        r_prev_row;
    logic                        r_out_valid;
    logic                        r_out_bit;
    logic [llag_pkg::MASK_W-1:0] r_birth;
    logic [llag_pkg::MASK_W-1:0] r_survive;

    logic [AW:0]          w_row_ext;
    logic [AW:0]          w_col_ext;
    logic [CW-1:0]        w_col_idx;
    logic                 w_hit;
    logic                 w_final;
    logic                 w_out_free;
    logic                 w_step;
    logic                 w_res_now;

    logic [GRID_SIZE-1:0] w_rows [GRID_SIZE];
    logic [GRID_SIZE-1:0] w_head;
    logic [GRID_SIZE-1:0] w_above;
    logic [GRID_SIZE-1:0] w_below;
    logic [GRID_SIZE-1:0] w_next_row;
    logic [GRID_SIZE-1:0] w_wr_row;
    logic [GRID_SIZE-1:0] w_tail;
    llag_pkg::t_cell_ctrl w_ctrl;

    assign w_row_ext = {{(AW + 1 - llag_pkg::ADDR_W){1'b0}}, r_row};
    assign w_col_ext = {{(AW + 1 - llag_pkg::ADDR_W){1'b0}}, r_col};
    assign w_col_idx = w_col_ext[CW-1:0];
    assign w_hit     = r_inside && (r_cnt == w_row_ext[CW-1:0]);

    // Step control: the last step needs room in the result register
    assign w_final    = (r_op == llag_pkg::OP_CLEAR) || (r_cnt == LAST);
    assign w_out_free = !r_out_valid || i_m_tready;
    assign w_step     = r_busy && (!w_final || w_out_free);

    assign w_ctrl.shift = w_step && (r_op != llag_pkg::OP_CLEAR);
    assign w_ctrl.clear = w_step && (r_op == llag_pkg::OP_CLEAR);

    // Ring of row cells; row 0 of the rotation sits at the head
    for (genvar g = 0; g < GRID_SIZE; g++) begin : g_cell
        logic [GRID_SIZE-1:0] w_feed;
        if (g == GRID_SIZE - 1) begin : g_tail
            assign w_feed = w_tail;
        end else begin : g_link
            assign w_feed = w_rows[g+1];
        end
        llag_cell #(
            .GRID_SIZE (GRID_SIZE)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctrl  (w_ctrl),
            .i_row   (w_feed),
            .o_row   (w_rows[g])
        );
    end

    assign w_head  = w_rows[0];
    assign w_above = (r_cnt == '0) ? '0 : r_prev_row;
    assign w_below = (r_cnt == LAST) ? '0 : w_rows[1];

    llag_rule #(
        .GRID_SIZE (GRID_SIZE)
    ) u_rule (
        .i_above   (w_above),
        .i_center  (w_head),
        .i_below   (w_below),
        .i_birth   (r_birth),
        .i_survive (r_survive),
        .o_next    (w_next_row)
    );

    // Head row with the addressed bit replaced
    always_comb begin
        w_wr_row = w_head;
        w_wr_row[w_col_idx] = r_val;
    end

    // Row that re-enters the ring at the tail
    always_comb begin
        case (r_op)
            llag_pkg::OP_ADVANCE: w_tail = w_next_row;
            llag_pkg::OP_WRITE:   w_tail = w_hit ? w_wr_row : w_head;
            default:              w_tail = w_head;
        endcase
    end

    assign w_res_now = ((r_op == llag_pkg::OP_READ) && w_hit) ? w_head[w_col_idx] : r_res;

    // Operation sequencing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            if (w_in_fire) begin
                r_busy <= 1'b1;
            end else if (w_step && w_final) begin
                r_busy <= 1'b0;
            end
            if (w_step) begin
                r_cnt <= w_final ? '0 : r_cnt + CW'(1);
            end
        end
    end

    // Operation payload
    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_op     <= w_in_op;
            r_row    <= w_in_row;
            r_col    <= w_in_col;
            r_val    <= w_in_val;
            r_inside <= w_in_inside;
            r_res    <= (w_in_op == llag_pkg::OP_WRITE) && w_in_inside && w_in_val;
        end else if (w_step) begin
            r_res <= w_res_now;
        end
        if (w_step) begin
            r_prev_row <= w_head;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step && w_final) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step && w_final) begin
            r_out_bit <= w_res_now;
        end
    end

    // Rule registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_birth   <= llag_pkg::BIRTH_RESET;
            r_survive <= llag_pkg::SURVIVE_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                llag_pkg::REG_BIRTH:   r_birth   <= i_cfg_data;
                llag_pkg::REG_SURVIVE: r_survive <= i_cfg_data;
                default:               r_birth   <= r_birth;
            endcase
        end
    end

    assign o_s_tready = !r_busy;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(llag_pkg::M_DATA_W - 1){1'b0}}, r_out_bit};

    // Checks
    a_fire_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_fire |=> r_busy)
        else $error("operation accepted but sequencer not busy");

    a_cnt_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> (r_cnt == '0))
        else $error("row counter not at zero while idle");

    a_out_from_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_busy))
        else $error("result appeared without an operation");

    a_ctrl_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_ctrl.shift && w_ctrl.clear))
        else $error("ring shift and clear at once");

endmodule

// File: hdl/llag_cell.sv
// One row cell of the ring: holds one grid row and passes it to its neighbor.
module llag_cell #(
    parameter int GRID_SIZE = llag_pkg::GRID_SIZE_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  llag_pkg::t_cell_ctrl   i_ctrl,
    input  logic [GRID_SIZE-1:0]   i_row,
    output logic [GRID_SIZE-1:0]   o_row
);

    logic [GRID_SIZE-1:0] r_row;

    // Row storage: clear wins, else take the neighbor's row on a shift
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
        end else if (i_ctrl.clear) begin
            r_row <= '0;
        end else if (i_ctrl.shift) begin
            r_row <= i_row;
        end
    end

    assign o_row = r_row;

endmodule

// File: hdl/llag_rule.sv
// Next-generation logic for one row from the rows above, at and below it.
module llag_rule #(
    parameter int GRID_SIZE = llag_pkg::GRID_SIZE_DEF
) (
    input  logic [GRID_SIZE-1:0]        i_above,
    input  logic [GRID_SIZE-1:0]        i_center,
    input  logic [GRID_SIZE-1:0]        i_below,
    input  logic [llag_pkg::MASK_W-1:0] i_birth,
    input  logic [llag_pkg::MASK_W-1:0] i_survive,
    output logic [GRID_SIZE-1:0]        o_next
);

    // Zero padding at both ends models dead cells past the edge
    logic [GRID_SIZE+1:0] w_up;
    logic [GRID_SIZE+1:0] w_mid;
    logic [GRID_SIZE+1:0] w_dn;

    assign w_up  = {1'b0, i_above,  1'b0};
    assign w_mid = {1'b0, i_center, 1'b0};
    assign w_dn  = {1'b0, i_below,  1'b0};

    for (genvar g = 0; g < GRID_SIZE; g++) begin : g_col
        logic [llag_pkg::COUNT_W-1:0] w_cnt;

        // Eight neighbors, padded column g+1 is this cell
        assign w_cnt = llag_pkg::COUNT_W'(w_up[g]) + llag_pkg::COUNT_W'(w_up[g+1])
                     + llag_pkg::COUNT_W'(w_up[g+2]) + llag_pkg::COUNT_W'(w_mid[g])
                     + llag_pkg::COUNT_W'(w_mid[g+2]) + llag_pkg::COUNT_W'(w_dn[g])
                     + llag_pkg::COUNT_W'(w_dn[g+1]) + llag_pkg::COUNT_W'(w_dn[g+2]);

        assign o_next[g] = i_center[g] ? i_survive[w_cnt] : i_birth[w_cnt];
    end

endmodule
